/* hw/rtl/zlh_pkg.sv */
package zlh_pkg;

  localparam logic [31:0] LocalSig = 32'h04034b50;
  localparam logic [31:0] AllOnes  = 32'hFFFFFFFF;
  localparam logic [15:0] WideTag  = 16'h0001;
  localparam int unsigned HdrLen   = 30;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAME    = 3'd1,
    PH_WALK    = 3'd2,
    PH_TAIL    = 3'd3,
    PH_DATA    = 3'd4,
    PH_STOPPED = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_BADSIG = 2'd1,
    KIND_STREAM_END = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [15:0] method;
    logic [15:0] gp_flags;
    logic [31:0] crc_value;
    logic [63:0] comp_size;
    logic [63:0] raw_size;
    logic [15:0] name_length;
    logic [15:0] extra_length;
    logic [31:0] dos_datetime;
    logic [63:0] data_offset;
    logic        is_dir;
  } result_t;

  // what the front hands to the back for one byte
  typedef struct packed {
    logic    res0_vld;
    logic    res1_vld;
    result_t res0;
    result_t res1;
  } work_t;

endpackage

/* hw/rtl/zlh_front.sv */
module zlh_front #(
  parameter int unsigned POSITION_BITS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  logic [7:0]      data_byte_i,
  input  logic            stream_end_i,
  output zlh_pkg::work_t  work_o
);
  import zlh_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]  hb_q [HdrLen];
  logic [63:0] skip_q, skip_d;
  logic [31:0] rhead_q, rhead_d;
  logic [15:0] roff_q, roff_d;
  logic        wfound_q, wfound_d;
  logic [63:0] wunc_q, wunc_d, wcomp_q, wcomp_d;
  logic [7:0]  lnb_q, lnb_d;

  // header bytes with the current byte folded in (signature on 30th byte)
  logic [7:0]  hb [HdrLen];
  always_comb begin
    for (int i = 0; i < HdrLen; i++) begin
      hb[i] = hb_q[i];
      if (phase_q == PH_HEADER && cnt_q == 16'(i)) hb[i] = data_byte_i;
    end
  end

  logic [31:0] sig, crc, csz32, usz32;
  logic [15:0] nlen, xlen;
  assign sig   = {hb[3], hb[2], hb[1], hb[0]};
  assign crc   = {hb[17], hb[16], hb[15], hb[14]};
  assign csz32 = {hb[21], hb[20], hb[19], hb[18]};
  assign usz32 = {hb[25], hb[24], hb[23], hb[22]};
  assign nlen  = {hb[27], hb[26]};
  assign xlen  = {hb[29], hb[28]};

  logic [15:0] cnt_inc;
  assign cnt_inc = cnt_q + 16'd1;

  // walk byte datapath
  logic [15:0] rel, dd;
  logic [15:0] rsize;
  logic        ut, ct, ut_f, ct_f;
  logic [16:0] rend;
  assign rel   = cnt_q - roff_q;
  assign dd    = rel - 16'd4;
  assign rsize = rhead_q[31:16];
  assign ut    = (usz32 == AllOnes) && (rsize >= 16'd8);
  assign ct    = (csz32 == AllOnes) && ({1'b0, ut ? 16'd8 : 16'd0} + 17'd8 <= {1'b0, rsize});
  assign ut_f  = wfound_d && (usz32 == AllOnes) && (rhead_d[31:16] >= 16'd8);
  assign ct_f  = wfound_d && (csz32 == AllOnes) &&
                 ({1'b0, ut_f ? 16'd8 : 16'd0} + 17'd8 <= {1'b0, rhead_d[31:16]});

  logic [31:0] rhead_b;
  always_comb begin
    rhead_b = rhead_q;
    case (rel[1:0])
      2'd0: rhead_b[7:0]   = rhead_q[7:0]   | data_byte_i;
      2'd1: rhead_b[15:8]  = rhead_q[15:8]  | data_byte_i;
      2'd2: rhead_b[23:16] = rhead_q[23:16] | data_byte_i;
      default: rhead_b[31:24] = rhead_q[31:24] | data_byte_i;
    endcase
  end
  assign rend = {1'b0, roff_q} + 17'd4 + {1'b0, rhead_b[31:16]};

  result_t ent, endr;
  logic [63:0] csz_sel;
  assign csz_sel = ct_f ? wcomp_d : {32'd0, csz32};
  always_comb begin
    ent = '0;
    ent.kind = KIND_ENTRY;
    ent.method = {hb[9], hb[8]};
    ent.gp_flags = {hb[7], hb[6]};
    ent.crc_value = crc;
    ent.comp_size = csz_sel;
    ent.raw_size = ut_f ? wunc_d : {32'd0, usz32};
    ent.name_length = nlen;
    ent.extra_length = xlen;
    ent.dos_datetime = {hb[13], hb[12], hb[11], hb[10]};
    ent.data_offset = 64'(pos_q + POSITION_BITS'(1));
    ent.is_dir = (nlen != 16'd0) && (lnb_d == 8'h2f);
    endr = '0;
  end

  logic emit_ent, emit_bad;
  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; skip_d = skip_q; rhead_d = rhead_q;
    roff_d = roff_q; wfound_d = wfound_q; wunc_d = wunc_q; wcomp_d = wcomp_q;
    lnb_d = lnb_q; emit_ent = 1'b0; emit_bad = 1'b0;
    pos_d = pos_q + POSITION_BITS'(1);
    case (phase_q)
      PH_HEADER: begin
        if (cnt_q == 16'd0) begin
          rhead_d = '0; roff_d = '0; wfound_d = 1'b0;
          wunc_d = '0; wcomp_d = '0; lnb_d = '0;
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= 16'(HdrLen)) begin
          cnt_d = '0;
          if (sig != LocalSig) begin
            emit_bad = 1'b1; phase_d = PH_STOPPED;
          end else if (nlen != 16'd0) phase_d = PH_NAME;
          else if (xlen != 16'd0) phase_d = PH_WALK;
          else emit_ent = 1'b1;
        end
      end
      PH_NAME: begin
        lnb_d = data_byte_i;
        cnt_d = cnt_inc;
        if (cnt_inc >= nlen) begin
          cnt_d = '0;
          if (xlen != 16'd0) phase_d = PH_WALK;
          else emit_ent = 1'b1;
        end
      end
      PH_WALK, PH_TAIL: begin
        if (phase_q == PH_WALK) begin
          if (!wfound_q) begin
            if (rel < 16'd4) begin
              rhead_d = rhead_b;
              if (rel == 16'd3) begin
                if (rend > {1'b0, xlen}) phase_d = PH_TAIL;
                else if (rhead_b[15:0] == WideTag) wfound_d = 1'b1;
                else begin
                  roff_d = rend[15:0]; rhead_d = '0;
                end
              end
            end
          end else if (rel >= 16'd4) begin
            if (ut && dd < 16'd8)
              wunc_d[dd[2:0]*8 +: 8] = wunc_q[dd[2:0]*8 +: 8] | data_byte_i;
            if (ct) begin
              if (ut && dd >= 16'd8 && dd < 16'd16)
                wcomp_d[dd[2:0]*8 +: 8] = wcomp_q[dd[2:0]*8 +: 8] | data_byte_i;
              else if (!ut && dd < 16'd8)
                wcomp_d[dd[2:0]*8 +: 8] = wcomp_q[dd[2:0]*8 +: 8] | data_byte_i;
            end
          end
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= xlen) emit_ent = 1'b1;
      end
      PH_DATA: begin
        skip_d = skip_q - 64'd1;
        if (skip_d == 64'd0) begin
          phase_d = PH_HEADER; cnt_d = '0;
        end
      end
      default: ;
    endcase
    if (emit_ent) begin
      skip_d = csz_sel;
      phase_d = (csz_sel != 64'd0) ? PH_DATA : PH_HEADER;
      cnt_d = '0;
    end
  end

  logic end_res;
  assign end_res = stream_end_i && !emit_bad && (phase_q != PH_STOPPED) &&
                   (phase_q <= PH_STOPPED);

  always_comb begin
    work_o = '0;
    work_o.res0 = emit_ent ? ent : endr;
    if (emit_bad) work_o.res0.kind = KIND_BADSIG;
    work_o.res1 = endr;
    work_o.res1.kind = KIND_STREAM_END;
    work_o.res1.last = 1'b1;
    work_o.res0_vld = in_vld_i && (emit_ent || emit_bad || end_res);
    work_o.res1_vld = in_vld_i && (emit_ent && end_res);
    if (!emit_ent && !emit_bad) work_o.res0.kind = KIND_STREAM_END;
    work_o.res0.last = !(emit_ent && end_res);
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_i && phase_q == PH_HEADER && cnt_q < 16'(HdrLen))
      hb_q[cnt_q[4:0]] <= data_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; cnt_q <= '0; pos_q <= '0; skip_q <= '0;
      rhead_q <= '0; roff_q <= '0; wfound_q <= 1'b0; wunc_q <= '0;
      wcomp_q <= '0; lnb_q <= '0;
    end else if (in_vld_i) begin
      if (stream_end_i) begin
        phase_q <= PH_HEADER; cnt_q <= '0; pos_q <= '0; skip_q <= '0;
        rhead_q <= '0; roff_q <= '0; wfound_q <= 1'b0; wunc_q <= '0;
        wcomp_q <= '0; lnb_q <= '0;
      end else begin
        phase_q <= phase_d; cnt_q <= cnt_d; pos_q <= pos_d; skip_q <= skip_d;
        rhead_q <= rhead_d; roff_q <= roff_d; wfound_q <= wfound_d;
        wunc_q <= wunc_d; wcomp_q <= wcomp_d; lnb_q <= lnb_d;
      end
    end
  end

`ifndef SYNTH
  a_one_needs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_o.res1_vld |-> work_o.res0_vld) else $error("second result without first");
  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STOPPED && !(in_vld_i && stream_end_i)) |=> phase_q == PH_STOPPED)
    else $error("left stopped phase early");
  a_no_emit_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_STOPPED) |-> !(emit_ent || emit_bad)) else $error("emit while stopped");
`endif

endmodule

/* hw/rtl/zlh_back.sv */
module zlh_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  zlh_pkg::work_t   work_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output zlh_pkg::result_t res_o
);
  import zlh_pkg::*;

  // four result slots; a byte needs up to two, so full keeps two free
  localparam int unsigned Depth = 4;
  result_t     mem_q [Depth];
  logic [1:0]  wp_q, rp_q;
  logic [2:0]  cnt_q;
  logic [1:0]  nin;
  logic        do_pop;

  assign do_pop  = pop_i && !empty_o;
  assign empty_o = (cnt_q == 3'd0);
  assign full_o  = (cnt_q > 3'd2);
  assign res_o   = mem_q[rp_q];
  assign nin     = (push_i && !full_o) ?
                   {1'b0, work_i.res0_vld} + {1'b0, work_i.res1_vld} : 2'd0;

  always_ff @(posedge clk_i) begin
    if (nin != 2'd0) mem_q[wp_q] <= work_i.res0;
    if (nin == 2'd2) mem_q[wp_q + 2'd1] <= work_i.res1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + nin;
      rp_q  <= rp_q + 2'(do_pop);
      cnt_q <= cnt_q + 3'(nin) - 3'(do_pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(Depth)) else $error("result queue overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i && do_pop) |=> cnt_q == $past(cnt_q) - 3'd1) else $error("count slip");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wp_q - rp_q) == cnt_q[1:0]) else $error("pointer gap");
`endif

endmodule

/* hw/rtl/zip_local_header_stream_parser.sv */
// Channel  Dir  Handshake    Payload
// input    in   push/full    data_byte_i, stream_end_i
// result   out  pop/empty    kind_o .. is_dir_o
// One byte per cycle while full is low; the header walk never stalls input.
// A byte may cause two results; a four-slot result queue takes them, and
// full rises while fewer than two slots are free.
// Reset is asynchronous; the result queue and walk state clear at once.
// A stall on the result side stops input only once the queue fills.
module zip_local_header_stream_parser #(
  parameter int unsigned POSITION_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic        last_o,
  output logic [15:0] method_o,
  output logic [15:0] gp_flags_o,
  output logic [31:0] crc_value_o,
  output logic [63:0] comp_size_o,
  output logic [63:0] raw_size_o,
  output logic [15:0] name_length_o,
  output logic [15:0] extra_length_o,
  output logic [31:0] dos_datetime_o,
  output logic [63:0] data_offset_o,
  output logic        is_dir_o
);
  import zlh_pkg::*;

  work_t   work;
  result_t res;
  logic    acc;

  assign acc = push && !full;

  zlh_front #(.POSITION_BITS(POSITION_BITS)) u_front (
    .clk_i, .rst_ni, .in_vld_i(acc), .data_byte_i, .stream_end_i, .work_o(work)
  );

  zlh_back u_back (
    .clk_i, .rst_ni, .push_i(push), .work_i(work), .full_o(full),
    .pop_i(pop), .empty_o(empty), .res_o(res)
  );

  assign kind_o = res.kind;
  assign last_o = res.last;
  assign method_o = res.method;
  assign gp_flags_o = res.gp_flags;
  assign crc_value_o = res.crc_value;
  assign comp_size_o = res.comp_size;
  assign raw_size_o = res.raw_size;
  assign name_length_o = res.name_length;
  assign extra_length_o = res.extra_length;
  assign dos_datetime_o = res.dos_datetime;
  assign data_offset_o = res.data_offset;
  assign is_dir_o = res.is_dir;

endmodule
